>>> design/strc_pkg.sv
// shared constants, types and helper functions for the scanline run centroid block
package strc_pkg;

  localparam int FRAC_BITS  = 4;
  localparam int ROW_PIXELS = 1024;
  localparam int RUN_CAP    = (ROW_PIXELS < 2047) ? ROW_PIXELS : 2047;

  localparam int COORD_W  = 13;
  localparam int BORDER_W = 10;
  localparam int CANVAS_W = 12;
  localparam int OUT_W    = 18;
  localparam int SUM_W    = 29;
  localparam int LEN_W    = 11;
  localparam int BOUND_W  = COORD_W + 2;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int LO_W     = DIFF_W + FRAC_BITS;
  localparam int MUL_W    = 2 * DIFF_W + FRAC_BITS;
  localparam int DIV_W    = MUL_W;
  localparam int DEN_W    = COORD_W;
  localparam int SAT_W    = DIV_W + 2;
  localparam int CNT_W    = $clog2(DIV_W);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_DEPTH_MIN     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH_MAX     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LATERAL_MIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LATERAL_MAX   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BORDER_OFFSET = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd6;

  localparam logic [COORD_W-1:0]        RST_DEPTH_MIN     = 13'd650;
  localparam logic [COORD_W-1:0]        RST_DEPTH_MAX     = 13'd1650;
  localparam logic signed [COORD_W-1:0] RST_LATERAL_MIN   = -13'sd300;
  localparam logic signed [COORD_W-1:0] RST_LATERAL_MAX   = 13'sd300;
  localparam logic [BORDER_W-1:0]       RST_BORDER_OFFSET = 10'd100;
  localparam logic [CANVAS_W-1:0]       RST_CANVAS_WIDTH  = 12'd800;
  localparam logic [CANVAS_W-1:0]       RST_CANVAS_HEIGHT = 12'd600;

  typedef struct packed {
    logic [COORD_W-1:0]        depth_min;
    logic [COORD_W-1:0]        depth_max;
    logic signed [COORD_W-1:0] lateral_min;
    logic signed [COORD_W-1:0] lateral_max;
    logic [BORDER_W-1:0]       border_offset;
    logic [CANVAS_W-1:0]       canvas_width;
    logic [CANVAS_W-1:0]       canvas_height;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] lateral_mm;
    logic [COORD_W-1:0]        depth_mm;
    logic                      row_end;
    logic                      in_win;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_LOAD,
    BK_DIV,
    BK_POST,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quotient;
  } div_rsp_t;

  typedef struct packed {
    back_state_t       state;
    logic [LEN_W-1:0]  run_len;
    logic              div_busy;
    logic              div_done;
  } bk_stat_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] vmax;
    logic signed [SAT_W-1:0] vmin;
    vmax = {{(SAT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    vmin = ~vmax;
    if (v > vmax) begin
      sat_out = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (v < vmin) begin
      sat_out = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_out = v[OUT_W-1:0];
    end
  endfunction

endpackage

>>> design/strc_if.sv
// point and centroid stream interfaces
interface strc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [strc_pkg::COORD_W-1:0] lateral_mm;
  logic [strc_pkg::COORD_W-1:0]        depth_mm;
  logic                               row_end;

  modport source (output valid, lateral_mm, depth_mm, row_end, input ready);
  modport sink (input valid, lateral_mm, depth_mm, row_end, output ready);
endinterface

interface strc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [strc_pkg::OUT_W-1:0] touch_x;
  logic signed [strc_pkg::OUT_W-1:0] touch_y;

  modport source (output valid, touch_x, touch_y, input ready);
  modport sink (input valid, touch_x, touch_y, output ready);
endinterface

>>> design/strc_front.sv
// front stage: takes points, tests the depth window and registers the tagged item
module strc_front (
  input  logic            clk,
  input  logic            rst_n,
  strc_in_if.sink         in_chan,
  input  strc_pkg::cfg_t  cfg,
  output logic            push_valid,
  input  logic            push_ready,
  output strc_pkg::item_t push_item
);

  logic                                valid_r;
  logic                                valid_nxt;
  strc_pkg::item_t                     item_r;
  logic signed [strc_pkg::BOUND_W-1:0] dep_s;
  logic signed [strc_pkg::BOUND_W-1:0] lo_bound;
  logic signed [strc_pkg::BOUND_W-1:0] hi_bound;
  logic signed [strc_pkg::BOUND_W-1:0] border_s;
  logic                                in_win;
  logic                                accept;

  assign dep_s    = $signed(strc_pkg::BOUND_W'(in_chan.depth_mm));
  assign border_s = $signed(strc_pkg::BOUND_W'(cfg.border_offset));
  assign lo_bound = $signed(strc_pkg::BOUND_W'(cfg.depth_min)) - border_s;
  assign hi_bound = $signed(strc_pkg::BOUND_W'(cfg.depth_max)) + border_s;
  assign in_win   = (dep_s > lo_bound) && (dep_s < hi_bound);

  assign in_chan.ready = !valid_r || push_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push_valid    = valid_r;
  assign push_item     = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.lateral_mm <= in_chan.lateral_mm;
      item_r.depth_mm   <= in_chan.depth_mm;
      item_r.row_end    <= in_chan.row_end;
      item_r.in_win     <= in_win;
    end
  end

endmodule

>>> design/strc_fifo.sv
// short item queue between the front and back stages
module strc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  strc_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output strc_pkg::item_t pop_item
);

  strc_pkg::item_t               mem_r [strc_pkg::QDEPTH];
  logic [strc_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [strc_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [strc_pkg::QPTR_W:0]     count_r;
  logic [strc_pkg::QPTR_W:0]     count_nxt;
  logic                          push;
  logic                          pop;

  assign push_ready = count_r != (strc_pkg::QPTR_W + 1)'(strc_pkg::QDEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/strc_div.sv
// shared restoring divider, one quotient bit per cycle
module strc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  strc_pkg::div_req_t req,
  output strc_pkg::div_rsp_t rsp
);

  logic                         busy_r;
  logic                         done_r;
  logic [strc_pkg::CNT_W-1:0]   cnt_r;
  logic [strc_pkg::DIV_W-1:0]   quo_r;
  logic [strc_pkg::DIV_W-1:0]   quo_nxt;
  logic [strc_pkg::DEN_W-1:0]   rem_r;
  logic [strc_pkg::DEN_W-1:0]   rem_nxt;
  logic [strc_pkg::DEN_W-1:0]   dvs_r;
  logic [strc_pkg::DEN_W:0]     trial;
  logic [strc_pkg::DEN_W:0]     diff;
  logic                         take;

  always_comb begin
    trial   = {rem_r, quo_r[strc_pkg::DIV_W-1]};
    diff    = trial - {1'b0, dvs_r};
    take    = trial >= {1'b0, dvs_r};
    rem_nxt = take ? diff[strc_pkg::DEN_W-1:0] : trial[strc_pkg::DEN_W-1:0];
    quo_nxt = {quo_r[strc_pkg::DIV_W-2:0], take};
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= strc_pkg::CNT_W'(strc_pkg::DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

>>> design/strc_back.sv
// back stage: maps inside points, keeps the run sums and computes the centroid
module strc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  strc_pkg::cfg_t      cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  strc_pkg::item_t     pop_item,
  output strc_pkg::div_req_t  div_req,
  input  strc_pkg::div_rsp_t  div_rsp,
  strc_out_if.source          out_chan,
  output strc_pkg::bk_stat_t  stat
);

  strc_pkg::back_state_t state_r;
  strc_pkg::back_state_t state_nxt;

  strc_pkg::item_t                      item_r;
  logic                                 pass_r;
  logic                                 mode_r;
  logic signed [strc_pkg::MUL_W-1:0]    prod_r;
  logic signed [strc_pkg::DIFF_W-1:0]   den_r;
  logic signed [strc_pkg::LO_W-1:0]     lo16_r;
  logic                                 zero_r;
  logic                                 neg_r;
  logic signed [strc_pkg::OUT_W-1:0]    res_x_r;
  logic signed [strc_pkg::OUT_W-1:0]    res_y_r;
  logic signed [strc_pkg::OUT_W-1:0]    out_x_r;
  logic signed [strc_pkg::OUT_W-1:0]    out_y_r;
  logic                                 out_valid_r;

  logic                                 active_r;
  logic                                 active_nxt;
  logic [strc_pkg::LEN_W-1:0]           len_r;
  logic [strc_pkg::LEN_W-1:0]           len_nxt;
  logic signed [strc_pkg::SUM_W-1:0]    sum_x_r;
  logic signed [strc_pkg::SUM_W-1:0]    sum_x_nxt;
  logic signed [strc_pkg::SUM_W-1:0]    sum_y_r;
  logic signed [strc_pkg::SUM_W-1:0]    sum_y_nxt;

  logic pop;
  logic can_add;
  logic start_map;
  logic start_cent;
  logic out_load;
  logic clear;

  logic signed [strc_pkg::DIFF_W-1:0]   v_s;
  logic signed [strc_pkg::DIFF_W-1:0]   a_s;
  logic signed [strc_pkg::DIFF_W-1:0]   b_s;
  logic signed [strc_pkg::DIFF_W-1:0]   d_s;
  logic signed [strc_pkg::DIFF_W-1:0]   span_s;
  logic signed [strc_pkg::DIFF_W-1:0]   lo_s;
  logic signed [strc_pkg::DIFF_W-1:0]   k_s;
  logic signed [strc_pkg::DIFF_W-1:0]   border_s;
  logic [strc_pkg::CANVAS_W-1:0]        size_u;
  logic signed [2*strc_pkg::DIFF_W-1:0] mp;
  logic signed [strc_pkg::MUL_W-1:0]    map_prod;
  logic signed [strc_pkg::SUM_W-1:0]    cent_sum;
  logic [strc_pkg::LEN_W+strc_pkg::CANVAS_W-1:0] nw;
  logic signed [strc_pkg::MUL_W-1:0]    cent_prod;
  logic signed [strc_pkg::DIFF_W-1:0]   cent_den;
  logic signed [strc_pkg::MUL_W-1:0]    mul_prod;
  logic signed [strc_pkg::DIFF_W-1:0]   mul_den;
  logic signed [strc_pkg::LO_W-1:0]     mul_lo16;

  logic [strc_pkg::DIV_W-1:0]           prod_abs;
  logic [strc_pkg::DIFF_W-1:0]          den_abs;
  logic signed [strc_pkg::SAT_W-1:0]    q_ext;
  logic signed [strc_pkg::SAT_W-1:0]    add_s;
  logic signed [strc_pkg::OUT_W-1:0]    post_val;

  assign pop        = pop_valid && pop_ready;
  assign can_add    = len_r < strc_pkg::LEN_W'(strc_pkg::RUN_CAP);
  assign start_map  = pop_item.in_win && can_add;
  assign start_cent = !pop_item.in_win && active_r && (len_r != '0);

  // operand set for the current pass: depth to x, lateral to y
  always_comb begin
    border_s = $signed(strc_pkg::DIFF_W'(cfg.border_offset));
    if (!pass_r) begin
      v_s      = $signed(strc_pkg::DIFF_W'(item_r.depth_mm));
      a_s      = $signed(strc_pkg::DIFF_W'(cfg.depth_min));
      b_s      = $signed(strc_pkg::DIFF_W'(cfg.depth_max));
      size_u   = cfg.canvas_width;
      cent_sum = sum_x_r;
    end else begin
      v_s      = strc_pkg::DIFF_W'(item_r.lateral_mm);
      a_s      = strc_pkg::DIFF_W'(cfg.lateral_min);
      b_s      = strc_pkg::DIFF_W'(cfg.lateral_max);
      size_u   = cfg.canvas_height;
      cent_sum = sum_y_r;
    end
    d_s       = v_s - a_s;
    span_s    = b_s - a_s;
    lo_s      = $signed(strc_pkg::DIFF_W'(size_u)) - border_s;
    k_s       = border_s - lo_s;
    mp        = d_s * k_s;
    map_prod  = strc_pkg::MUL_W'(mp) <<< strc_pkg::FRAC_BITS;
    nw        = len_r * size_u;
    cent_prod = (strc_pkg::MUL_W'(cent_sum) <<< 1)
              - ($signed(strc_pkg::MUL_W'(nw)) <<< strc_pkg::FRAC_BITS);
    cent_den  = $signed(strc_pkg::DIFF_W'({len_r, 1'b0}));
    if (mode_r) begin
      mul_prod = cent_prod;
      mul_den  = cent_den;
      mul_lo16 = '0;
    end else begin
      mul_prod = map_prod;
      mul_den  = span_s;
      mul_lo16 = strc_pkg::LO_W'(lo_s) <<< strc_pkg::FRAC_BITS;
    end
  end

  // magnitudes and rounding bias for the divider
  always_comb begin
    prod_abs = prod_r[strc_pkg::MUL_W-1] ? strc_pkg::DIV_W'(-prod_r)
                                         : strc_pkg::DIV_W'(prod_r);
    den_abs  = den_r[strc_pkg::DIFF_W-1] ? strc_pkg::DIFF_W'(-den_r)
                                         : strc_pkg::DIFF_W'(den_r);
    div_req.dividend = prod_abs + strc_pkg::DIV_W'(den_abs[strc_pkg::DEN_W-1:1]);
    div_req.divisor  = den_abs[strc_pkg::DEN_W-1:0];
  end

  always_comb begin
    q_ext = $signed({2'b00, div_rsp.quotient});
    if (zero_r) begin
      add_s = '0;
    end else if (neg_r) begin
      add_s = -q_ext;
    end else begin
      add_s = q_ext;
    end
    post_val = strc_pkg::sat_out(strc_pkg::SAT_W'(lo16_r) + add_s);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      strc_pkg::BK_IDLE: begin
        if (pop && (start_map || start_cent)) begin
          state_nxt = strc_pkg::BK_MUL;
        end
      end
      strc_pkg::BK_MUL: begin
        state_nxt = (mul_den == '0) ? strc_pkg::BK_POST : strc_pkg::BK_LOAD;
      end
      strc_pkg::BK_LOAD: begin
        state_nxt = strc_pkg::BK_DIV;
      end
      strc_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          state_nxt = strc_pkg::BK_POST;
        end
      end
      strc_pkg::BK_POST: begin
        if (!pass_r) begin
          state_nxt = strc_pkg::BK_MUL;
        end else if (mode_r) begin
          state_nxt = strc_pkg::BK_EMIT;
        end else begin
          state_nxt = strc_pkg::BK_IDLE;
        end
      end
      strc_pkg::BK_EMIT: begin
        if (out_load) begin
          state_nxt = strc_pkg::BK_IDLE;
        end
      end
      default: state_nxt = strc_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_ready     = 1'b0;
    div_req.start = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      strc_pkg::BK_IDLE: pop_ready     = 1'b1;
      strc_pkg::BK_LOAD: div_req.start = 1'b1;
      strc_pkg::BK_EMIT: out_load      = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  // run bookkeeping
  always_comb begin
    active_nxt = active_r;
    len_nxt    = len_r;
    sum_x_nxt  = sum_x_r;
    sum_y_nxt  = sum_y_r;
    clear      = 1'b0;
    if (pop && !start_map && !start_cent) begin
      if (pop_item.in_win && !pop_item.row_end) begin
        active_nxt = 1'b1;
      end else begin
        clear = 1'b1;
      end
    end
    if ((state_r == strc_pkg::BK_POST) && pass_r) begin
      if (mode_r || item_r.row_end) begin
        clear = 1'b1;
      end else begin
        sum_x_nxt  = sum_x_r + strc_pkg::SUM_W'(res_x_r);
        sum_y_nxt  = sum_y_r + strc_pkg::SUM_W'(post_val);
        len_nxt    = strc_pkg::LEN_W'(len_r + 1'b1);
        active_nxt = 1'b1;
      end
    end
    if (clear) begin
      active_nxt = 1'b0;
      len_nxt    = '0;
      sum_x_nxt  = '0;
      sum_y_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= strc_pkg::BK_IDLE;
      active_r    <= 1'b0;
      len_r       <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      len_r    <= len_nxt;
      sum_x_r  <= sum_x_nxt;
      sum_y_r  <= sum_y_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= pop_item;
      pass_r <= 1'b0;
      mode_r <= start_cent;
    end
    if (state_r == strc_pkg::BK_MUL) begin
      prod_r <= mul_prod;
      den_r  <= mul_den;
      lo16_r <= mul_lo16;
      zero_r <= mul_den == '0;
    end
    if (state_r == strc_pkg::BK_LOAD) begin
      neg_r <= prod_r[strc_pkg::MUL_W-1] ^ den_r[strc_pkg::DIFF_W-1];
    end
    if (state_r == strc_pkg::BK_POST) begin
      if (!pass_r) begin
        res_x_r <= post_val;
        pass_r  <= 1'b1;
      end else begin
        res_y_r <= post_val;
      end
    end
    if (out_load) begin
      out_x_r <= res_x_r;
      out_y_r <= res_y_r;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.touch_x = out_x_r;
  assign out_chan.touch_y = out_y_r;

  assign stat.state    = state_r;
  assign stat.run_len  = len_r;
  assign stat.div_busy = div_rsp.busy;
  assign stat.div_done = div_rsp.done;

endmodule

>>> design/scanline_touch_run_centroid.sv
// top level of the scanline run centroid detector with its register file
// Points enter through in_chan. A point inside the depth window and one that closes a run
// each need two quotients from one shared restoring divider that produces one bit per
// cycle over a 32-bit dividend; a zero calibration span skips its division, and other
// points pass the back stage without one. A four-entry queue between the window test and
// the back stage lets points keep arriving while the divider works. A run closed by a
// point outside the window yields one centroid on out_chan, relative to the canvas centre
// in 1/16 pixel; one ended by an in-window row end yields none. APB registers sit at byte
// address 4*i; the user must write them only while idle, which the block does not enforce.
module scanline_touch_run_centroid (
  input  logic                          clk,
  input  logic                          rst_n,
  strc_in_if.sink                       in_chan,
  strc_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [strc_pkg::ADDR_W-1:0]   paddr,
  input  logic [strc_pkg::DATA_W-1:0]   pwdata,
  output logic [strc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  strc_pkg::cfg_t     cfg_r;
  strc_pkg::cfg_t     cfg_nxt;
  logic               wr_en;
  logic [strc_pkg::REG_IDX_W-1:0] reg_idx;

  logic               q_push_valid;
  logic               q_push_ready;
  strc_pkg::item_t    q_push_item;
  logic               q_pop_valid;
  logic               q_pop_ready;
  strc_pkg::item_t    q_pop_item;
  strc_pkg::div_req_t div_req;
  strc_pkg::div_rsp_t div_rsp;
  strc_pkg::bk_stat_t bk_stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[strc_pkg::ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        strc_pkg::REG_DEPTH_MIN:     cfg_nxt.depth_min     = pwdata[strc_pkg::COORD_W-1:0];
        strc_pkg::REG_DEPTH_MAX:     cfg_nxt.depth_max     = pwdata[strc_pkg::COORD_W-1:0];
        strc_pkg::REG_LATERAL_MIN:   cfg_nxt.lateral_min   = pwdata[strc_pkg::COORD_W-1:0];
        strc_pkg::REG_LATERAL_MAX:   cfg_nxt.lateral_max   = pwdata[strc_pkg::COORD_W-1:0];
        strc_pkg::REG_BORDER_OFFSET: cfg_nxt.border_offset = pwdata[strc_pkg::BORDER_W-1:0];
        strc_pkg::REG_CANVAS_WIDTH:  cfg_nxt.canvas_width  = pwdata[strc_pkg::CANVAS_W-1:0];
        strc_pkg::REG_CANVAS_HEIGHT: cfg_nxt.canvas_height = pwdata[strc_pkg::CANVAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_min     <= strc_pkg::RST_DEPTH_MIN;
      cfg_r.depth_max     <= strc_pkg::RST_DEPTH_MAX;
      cfg_r.lateral_min   <= strc_pkg::RST_LATERAL_MIN;
      cfg_r.lateral_max   <= strc_pkg::RST_LATERAL_MAX;
      cfg_r.border_offset <= strc_pkg::RST_BORDER_OFFSET;
      cfg_r.canvas_width  <= strc_pkg::RST_CANVAS_WIDTH;
      cfg_r.canvas_height <= strc_pkg::RST_CANVAS_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      strc_pkg::REG_DEPTH_MIN:     prdata = strc_pkg::DATA_W'(cfg_r.depth_min);
      strc_pkg::REG_DEPTH_MAX:     prdata = strc_pkg::DATA_W'(cfg_r.depth_max);
      strc_pkg::REG_LATERAL_MIN:   prdata = strc_pkg::DATA_W'(cfg_r.lateral_min);
      strc_pkg::REG_LATERAL_MAX:   prdata = strc_pkg::DATA_W'(cfg_r.lateral_max);
      strc_pkg::REG_BORDER_OFFSET: prdata = strc_pkg::DATA_W'(cfg_r.border_offset);
      strc_pkg::REG_CANVAS_WIDTH:  prdata = strc_pkg::DATA_W'(cfg_r.canvas_width);
      strc_pkg::REG_CANVAS_HEIGHT: prdata = strc_pkg::DATA_W'(cfg_r.canvas_height);
      default:                     prdata = '0;
    endcase
  end

  strc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg        (cfg_r),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item)
  );

  strc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  strc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  strc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_item  (q_pop_item),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_chan  (out_chan),
    .stat      (bk_stat)
  );

  a_run_cap: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.run_len <= strc_pkg::LEN_W'(strc_pkg::RUN_CAP))
    else $error("run length beyond cap");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(bk_stat.state) == strc_pkg::BK_EMIT)
    else $error("centroid transaction not issued from the emit state");

  a_div_live: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.state == strc_pkg::BK_DIV |-> bk_stat.div_busy || bk_stat.div_done)
    else $error("waiting on an idle divider");

endmodule
